// ----- src/bms_pkg.sv -----
// ----------------------------------------------------------------------------
// bms_pkg
// Shared types and constants of the button matrix scanner.
// ----------------------------------------------------------------------------
package bms_pkg;

  localparam int ROWS       = 16;
  localparam int PINS       = 16;
  localparam int ROW_W      = 4;
  localparam int NOTE_W     = 7;
  localparam int VEL_W      = 7;
  localparam int DRIVE_W    = 16;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  localparam logic [NOTE_W-1:0] BASE_NOTE_RESET = 7'h3c;
  localparam logic [VEL_W-1:0]  VEL_PRESS       = 7'h7f;
  localparam logic [VEL_W-1:0]  VEL_RELEASE     = 7'h00;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMPTY
  } scan_state_t;

  // Note event produced by the shared note unit.
  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;
  } evt_t;

endpackage

// ----- src/bms_row_store.sv -----
// ----------------------------------------------------------------------------
// bms_row_store
// Per-row storage of the last sampled pin words, one entry per row.
// ----------------------------------------------------------------------------
module bms_row_store #(
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [bms_pkg::ROW_W-1:0] addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_data
);
  import bms_pkg::*;

  logic [WIDTH-1:0] mem_r [ROWS];

  // Reset value is all ones: every button released.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROWS; i++) begin
        mem_r[i] <= '1;
      end
    end else if (wr_en) begin
      mem_r[addr] <= wr_data;
    end
  end

  assign rd_data = mem_r[addr];

endmodule

// ----- src/bms_note_unit.sv -----
// ----------------------------------------------------------------------------
// bms_note_unit
// Shared note adder: turns a pin position and its sample into a note event.
// ----------------------------------------------------------------------------
module bms_note_unit #(
  parameter int IDX_W = 5
) (
  input  logic [bms_pkg::NOTE_W-1:0] base_note,
  input  logic [IDX_W-1:0]           pin_idx,
  input  logic                       sample_bit,
  output bms_pkg::evt_t              evt
);
  import bms_pkg::*;

  logic [NOTE_W-1:0] idx_ext;

  // The position already folds matrix*16 + pin; the sum wraps at 128.
  assign idx_ext      = {{(NOTE_W-IDX_W){1'b0}}, pin_idx};
  assign evt.note     = base_note + idx_ext;
  assign evt.velocity = sample_bit ? VEL_RELEASE : VEL_PRESS;

endmodule

// ----- src/button_matrix_scanner_top.sv -----
// ----------------------------------------------------------------------------
// button_matrix_scanner_top
// Row-at-a-time scanner of up to two 16x16 button matrices with note events.
// ----------------------------------------------------------------------------
// Each input beat is one scan tick: it carries the active-low pin samples of
// both matrices taken while the previous row was driven. On acceptance the
// block advances its row counter, compares the samples against the stored
// row words and stores the new ones. A sequencer then walks the pin
// positions one per cycle (matrix 0 pins 0 to 15, then matrix 1), holding at
// a changed pin while the output stage is full, and for every changed pin a
// shared note adder forms one result beat. The walk ends after the highest
// changed position; a tick with no change yields a single beat with tuser
// low. The input is ready only while the sequencer is idle. A registered
// output stage holds each result beat, so the next tick can be taken while
// the final beat of the previous tick still waits. Every beat carries the
// new active-low row select, and tlast marks the final beat of a tick.
// ----------------------------------------------------------------------------
module button_matrix_scanner_top #(
  parameter int MATRIX_COUNT = 2
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input beat, tdata fields from bit 0: samples_first[15:0],
  // samples_second[31:16].
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bms_pkg::IN_DATA_W-1:0]    in_tdata,
  // Result beat, tdata fields from bit 0: row_drive[15:0],
  // midi_channel[19:16], note_number[26:20], velocity[33:27], zeros[39:34].
  // tuser holds event_valid; tlast holds last_result.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bms_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tuser,
  output logic                             out_tlast,
  // Configuration: base_note.
  input  logic                             cfg_wr_en,
  input  logic [bms_pkg::NOTE_W-1:0]       cfg_wr_data
);
  import bms_pkg::*;

  localparam int NBITS = MATRIX_COUNT * PINS;
  localparam int IDX_W = $clog2(NBITS);

  scan_state_t state_r, state_nxt;

  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [ROW_W-1:0]   chan_r, chan_nxt;
  logic [DRIVE_W-1:0] drive_r, drive_nxt;
  logic [NBITS-1:0]   samples_r, samples_nxt;
  logic [NBITS-1:0]   changed_r, changed_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [NOTE_W-1:0]  base_r;

  logic               out_valid_r, out_valid_nxt;
  logic [DRIVE_W-1:0] out_drive_r, out_drive_nxt;
  logic [ROW_W-1:0]   out_chan_r, out_chan_nxt;
  logic [NOTE_W-1:0]  out_note_r, out_note_nxt;
  logic [VEL_W-1:0]   out_vel_r, out_vel_nxt;
  logic               out_user_r, out_user_nxt;
  logic               out_last_r, out_last_nxt;

  logic               accept;
  logic               slot_free;
  logic [NBITS-1:0]   in_samples;
  logic [NBITS-1:0]   store_rdata;
  logic [NBITS-1:0]   remaining;
  evt_t               evt;

  assign in_samples = in_tdata[NBITS-1:0];
  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign slot_free  = !out_valid_r || out_tready;
  // Change bits still pending once the current position is served.
  assign remaining  = changed_r & ~(NBITS'(1) << idx_r);

  // Row store, read and written at the row that was just scanned.
  bms_row_store #(
    .WIDTH (NBITS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .addr    (row_r),
    .wr_data (in_samples),
    .rd_data (store_rdata)
  );

  bms_note_unit #(
    .IDX_W (IDX_W)
  ) u_note (
    .base_note  (base_r),
    .pin_idx    (idx_r),
    .sample_bit (samples_r[idx_r]),
    .evt        (evt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    chan_nxt      = chan_r;
    drive_nxt     = drive_r;
    samples_nxt   = samples_r;
    changed_nxt   = changed_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_drive_nxt = out_drive_r;
    out_chan_nxt  = out_chan_r;
    out_note_nxt  = out_note_r;
    out_vel_nxt   = out_vel_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          row_nxt     = row_r + 1'b1;
          chan_nxt    = row_r;
          drive_nxt   = ~(DRIVE_W'(1) << row_nxt);
          samples_nxt = in_samples;
          changed_nxt = in_samples ^ store_rdata;
          idx_nxt     = '0;
          state_nxt   = ((in_samples ^ store_rdata) == '0) ? ST_EMPTY : ST_SCAN;
        end
      end
      ST_EMPTY: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_drive_nxt = drive_r;
          out_chan_nxt  = '0;
          out_note_nxt  = '0;
          out_vel_nxt   = '0;
          out_user_nxt  = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (changed_r[idx_r]) begin
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_drive_nxt = drive_r;
            out_chan_nxt  = chan_r;
            out_note_nxt  = evt.note;
            out_vel_nxt   = evt.velocity;
            out_user_nxt  = 1'b1;
            out_last_nxt  = (remaining == '0);
            changed_nxt   = remaining;
            idx_nxt       = idx_r + 1'b1;
            if (remaining == '0) begin
              state_nxt = ST_IDLE;
            end
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      base_r      <= BASE_NOTE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        base_r <= cfg_wr_data;
      end
    end
  end

  // Working and payload registers need no reset.
  always_ff @(posedge clk) begin
    chan_r      <= chan_nxt;
    drive_r     <= drive_nxt;
    samples_r   <= samples_nxt;
    changed_r   <= changed_nxt;
    idx_r       <= idx_nxt;
    out_drive_r <= out_drive_nxt;
    out_chan_r  <= out_chan_nxt;
    out_note_r  <= out_note_nxt;
    out_vel_r   <= out_vel_nxt;
    out_user_r  <= out_user_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-DRIVE_W-ROW_W-NOTE_W-VEL_W){1'b0}},
                       out_vel_r, out_note_r, out_chan_r, out_drive_r};
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  // An accepted tick always starts either a scan or an empty result.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_SCAN || state_r == ST_EMPTY))
    else $error("accepted tick did not start the sequencer");

  // The row counter advances by one on every accepted tick.
  a_row_advance: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> row_r == ROW_W'($past(row_r) + 1'b1))
    else $error("row counter did not advance");

  // A scan in progress always has a pending change bit.
  a_scan_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (changed_r != '0))
    else $error("scan running with no pending change");

  // A beat without an event is only the single beat of a quiet tick.
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> out_tlast)
    else $error("non-event beat not marked last");
`endif

endmodule

// ----- sim/bms_scan_checker.sv -----
// ----------------------------------------------------------------------------
// bms_scan_checker
// Watches the scanner's channels, predicts every result beat and compares.
// ----------------------------------------------------------------------------
// The checker keeps its own row counter, stored row words and base note. Each
// accepted input beat adds its note beats, or one empty beat, to a queue.
// Each accepted output beat is checked field by field against the oldest
// queued beat.
// ----------------------------------------------------------------------------
module bms_scan_checker #(
  parameter int MATRIX_COUNT = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [bms_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [bms_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           out_tuser,
  input  logic                           out_tlast,
  input  logic                           cfg_wr_en,
  input  logic [bms_pkg::NOTE_W-1:0]     cfg_wr_data,
  output int                             fault_count,
  output int                             beats_owed
);
  import bms_pkg::*;

  typedef struct packed {
    logic [DRIVE_W-1:0] row_drive;
    logic               has_note;
    logic [ROW_W-1:0]   channel;
    logic [NOTE_W-1:0]  note;
    logic [VEL_W-1:0]   velocity;
    logic               final_beat;
  } note_beat_t;

  logic [ROW_W-1:0]  scan_row;
  logic [PINS-1:0]   row_words [2*ROWS];
  logic [NOTE_W-1:0] base_note;
  note_beat_t        beat_q [$];

  // Expands one scan tick into the note beats it must produce.
  task automatic predict_tick(input logic [IN_DATA_W-1:0] data);
    logic [DRIVE_W-1:0] drive;
    logic [ROW_W-1:0]   prev_row;
    logic [PINS-1:0]    sample [2];
    logic [PINS-1:0]    changed [2];
    note_beat_t         b;
    int                 total;
    int                 k;
    scan_row = scan_row + 1'b1;
    drive    = ~(DRIVE_W'(1) << scan_row);
    prev_row = scan_row - 1'b1;
    total    = 0;
    for (int m = 0; m < 2; m++) begin
      sample[m]  = data[m*PINS +: PINS];
      changed[m] = '0;
      if (m < MATRIX_COUNT) begin
        changed[m] = sample[m] ^ row_words[m*ROWS + prev_row];
        row_words[m*ROWS + prev_row] = sample[m];
        total += $countones(changed[m]);
      end
    end
    if (total == 0) begin
      b = '{row_drive: drive, has_note: 1'b0, channel: '0, note: '0,
            velocity: '0, final_beat: 1'b1};
      beat_q.push_back(b);
    end else begin
      k = 0;
      for (int m = 0; m < 2; m++) begin
        for (int pin = 0; pin < PINS; pin++) begin
          if (changed[m][pin]) begin
            b.row_drive  = drive;
            b.has_note   = 1'b1;
            b.channel    = prev_row;
            b.note       = base_note + NOTE_W'(m*16 + pin);
            b.velocity   = sample[m][pin] ? VEL_RELEASE : VEL_PRESS;
            b.final_beat = (k == total - 1);
            beat_q.push_back(b);
            k++;
          end
        end
      end
    end
  endtask

  task automatic compare_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", label, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    note_beat_t want;
    if (!rst_n) begin
      scan_row  = '0;
      base_note = BASE_NOTE_RESET;
      for (int i = 0; i < 2*ROWS; i++) row_words[i] = '1;
      beat_q.delete();
      fault_count = 0;
    end else begin
      if (cfg_wr_en) base_note = cfg_wr_data;
      if (in_tvalid && in_tready) predict_tick(in_tdata);
      if (out_tvalid && out_tready) begin
        if (beat_q.size() == 0) begin
          $error("result beat arrived with no beat expected");
          fault_count++;
        end else begin
          want = beat_q.pop_front();
          compare_field("row_drive", 32'(want.row_drive), 32'(out_tdata[15:0]));
          compare_field("event_valid", 32'(want.has_note), 32'(out_tuser));
          compare_field("midi_channel", 32'(want.channel), 32'(out_tdata[19:16]));
          compare_field("note_number", 32'(want.note), 32'(out_tdata[26:20]));
          compare_field("velocity", 32'(want.velocity), 32'(out_tdata[33:27]));
          compare_field("last_result", 32'(want.final_beat), 32'(out_tlast));
          compare_field("tdata padding", 32'd0, 32'(out_tdata[39:34]));
        end
      end
    end
    beats_owed <= beat_q.size();
  end

endmodule

// ----- sim/button_matrix_scanner_top_test.sv -----
// ----------------------------------------------------------------------------
// button_matrix_scanner_top_test
// Stimulus and verdict for the button matrix scanner.
// ----------------------------------------------------------------------------
// A short directed sequence walks the rows with no-change ticks, full presses
// and releases, single edge pins and alternating patterns. Random phases then
// follow, each under its own base note, among them 0, 127 and a value that
// makes notes wrap. Random ticks most often change a few pins of the row word
// last sent for that row, so press and release events dominate. Both sides
// idle at random, and once the receiver holds off long enough to stall the
// input. Checking is done by bms_scan_checker.
// ----------------------------------------------------------------------------
module button_matrix_scanner_top_test;
  import bms_pkg::*;

  localparam int SCAN_MATRICES = 2;
  localparam int TICKS_PER_PHASE = 40;
  // Idle stretch after draining; it covers the worst tick.
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_OFF_CYCLES = 400;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_wr_en;
  logic [NOTE_W-1:0]     cfg_wr_data;

  int scan_faults;
  int beats_owed;

  // Number of scan ticks accepted so far; its low four bits name the row
  // that the next tick reports on.
  int ticks_sent;
  // Row words as last sent, matrix*16 + row, so that random ticks can make
  // small changes against what the block has stored.
  logic [PINS-1:0] sent_words [2*ROWS];
  bit pressure_done;

  button_matrix_scanner_top #(
    .MATRIX_COUNT(SCAN_MATRICES)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  bms_scan_checker #(
    .MATRIX_COUNT(SCAN_MATRICES)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fault_count(scan_faults),
    .beats_owed (beats_owed)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Mostly back-to-back beats, some short gaps and a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Builds the next random tick from the words last sent for the same row.
  // Most often a matrix sees a few pins flip; otherwise it stays unchanged,
  // goes fully random, goes all pressed or all released, or flips every pin.
  function automatic logic [IN_DATA_W-1:0] random_tick();
    logic [IN_DATA_W-1:0] data;
    logic [PINS-1:0]      word;
    int                   r;
    for (int m = 0; m < 2; m++) begin
      word = sent_words[m*ROWS + (ticks_sent % ROWS)];
      r = $urandom_range(0, 99);
      if (r < 45) begin
        repeat ($urandom_range(1, 3)) word[$urandom_range(0, PINS-1)] ^= 1'b1;
      end else if (r < 65) begin
        word = word;
      end else if (r < 80) begin
        word = PINS'($urandom());
      end else if (r < 90) begin
        word = $urandom_range(0, 1) ? '1 : '0;
      end else begin
        word = ~word;
      end
      data[m*PINS +: PINS] = word;
    end
    return data;
  endfunction

  // Offers one tick after an optional idle gap and returns at the edge that
  // accepts it. tvalid stays high when the next tick follows with no gap.
  task automatic send_tick(input logic [IN_DATA_W-1:0] data, input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= IN_DATA_W'($urandom());
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    for (int m = 0; m < 2; m++) sent_words[m*ROWS + (ticks_sent % ROWS)] = data[m*PINS +: PINS];
    ticks_sent++;
  endtask

  // Stops offering ticks and waits until every predicted beat has come out,
  // then gives the block its worst-case tick time to settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (beats_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The base note is only changed while the block is idle.
  task automatic write_base_note(input logic [NOTE_W-1:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Receiver: runs of steady readiness, short stalls and occasional long
  // ones. Once, well into the random part, it holds off for a long stretch
  // while the sender keeps offering ticks, so the output stage fills and the
  // block stops taking input.
  initial begin : receiver
    int r;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!pressure_done && ticks_sent >= 75) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        pressure_done = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_tready <= 1'b1;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end else if (r < 90) begin
          out_tready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          out_tready <= 1'b0;
          repeat ($urandom_range(20, 50)) @(posedge clk);
        end
      end
    end
  end

  // Timeout: far beyond the slowest correct run, where every tick changes
  // all 32 pins and every beat waits out a long receiver stall.
  initial begin
    #12_000_000;
    $display("button_matrix_scanner_top_test: errors");
    $finish;
  end

  initial begin : stimulus
    logic [IN_DATA_W-1:0] directed_ticks [20];
    logic [NOTE_W-1:0]    phase_bases [5];
    ticks_sent    = 0;
    pressure_done = 1'b0;
    for (int i = 0; i < 2*ROWS; i++) sent_words[i] = '1;

    // Directed ticks, written as {samples_second, samples_first}. The
    // entry index is also the row that the tick reports on, modulo 16.
    directed_ticks = '{
      {16'hFFFF, 16'hFFFF},   // row 0: nothing changes, one empty beat
      {16'h0000, 16'h0000},   // row 1: all 32 pins pressed
      {16'hFFFF, 16'hFFFE},   // row 2: lowest pin of matrix zero
      {16'h7FFF, 16'hFFFF},   // row 3: highest pin of matrix one
      {16'h5555, 16'hAAAA},   // row 4: alternating patterns
      {16'hFFFE, 16'h7FFF},   // row 5: top pin of matrix zero, pin 0 of one
      {16'hFFFF, 16'hFFFF}, {16'hFFFF, 16'hFFFF}, {16'hFFFF, 16'hFFFF},
      {16'hFFFF, 16'hFFFF}, {16'hFFFF, 16'hFFFF}, {16'hFFFF, 16'hFFFF},
      {16'hFFFF, 16'hFFFF}, {16'hFFFF, 16'hFFFF}, {16'hFFFF, 16'hFFFF},
      {16'hFFFF, 16'hFFFF},   // rows 6 to 15: quiet
      {16'hFFFF, 16'h0000},   // row 0 again: matrix zero only
      {16'hFFFF, 16'hFFFF},   // row 1: all 32 pins released
      {16'hFFFF, 16'hFFFF},   // row 2: one release
      {16'hAAAA, 16'h5555}    // row 3: release and presses mixed
    };
    // Base notes per random phase: the extremes, one that wraps past 127 from
    // the top pin of matrix zero on, and two random settings.
    phase_bases[0] = 7'd127;
    phase_bases[1] = 7'd0;
    phase_bases[2] = 7'd113;
    phase_bases[3] = NOTE_W'($urandom());
    phase_bases[4] = NOTE_W'($urandom());

    // Every input is known from time zero; reset is held low at the start.
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset base note.
    foreach (directed_ticks[i]) send_tick(directed_ticks[i], pick_gap());

    // Random phases, each under a new base note.
    foreach (phase_bases[p]) begin
      write_base_note(phase_bases[p]);
      repeat (TICKS_PER_PHASE) send_tick(random_tick(), pick_gap());
    end

    drain();
    if (scan_faults == 0 && beats_owed == 0) begin
      $display("button_matrix_scanner_top_test: clean");
    end else begin
      $display("button_matrix_scanner_top_test: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/bms_pkg.sv
src/bms_row_store.sv
src/bms_note_unit.sv
src/button_matrix_scanner_top.sv
sim/bms_scan_checker.sv
sim/button_matrix_scanner_top_test.sv
